>>> design/tptw_pkg.sv
// Shared types, codes and helpers for the touch point transform watchdog.
package tptw_pkg;

  // Point slots handled per packet
  localparam int NUM_SLOTS = 2;

  // Default watchdog counter width
  localparam int COUNT_BITS = 16;

  // Point state that marks a touching finger
  localparam logic [1:0] ACTIVE_STATE = 2'd2;

  // Item function codes
  localparam logic [1:0] FUNC_PACKET = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_CLOSE  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_WIDTH    = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_HEIGHT   = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SWAP_AXES      = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIRROR_RAW_X   = 8'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIRROR_RAW_Y   = 8'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_QUARTER_TURNS  = 8'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_REFLECT_MODE   = 8'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_WATCHDOG_TICKS = 8'd7;

  // Quarter-turn codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_270  = 2'd3;

  typedef struct packed {
    logic [15:0] panel_width;
    logic [15:0] panel_height;
    logic        swap_axes;
    logic        mirror_raw_x;
    logic        mirror_raw_y;
    logic [1:0]  quarter_turns;
    logic [1:0]  reflect_mode;
    logic [15:0] watchdog_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  first_slot;
    logic [1:0]  first_state;
    logic [15:0] first_x;
    logic [15:0] first_y;
    logic [7:0]  second_slot;
    logic [1:0]  second_state;
    logic [15:0] second_x;
    logic [15:0] second_y;
  } in_item_t;

  typedef struct packed {
    logic        frame_kind;
    logic        first_used;
    logic        first_slot_out;
    logic        first_active;
    logic [15:0] first_disp_x;
    logic [15:0] first_disp_y;
    logic        second_used;
    logic        second_slot_out;
    logic        second_active;
    logic [15:0] second_disp_x;
    logic [15:0] second_disp_y;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic [1:0]  state;
    logic [15:0] x;
    logic [15:0] y;
  } point_in_t;

  typedef struct packed {
    logic        used;
    logic        slot;
    logic        active;
    logic [15:0] disp_x;
    logic [15:0] disp_y;
  } point_out_t;

  // Watchdog request for one accepted beat
  typedef struct packed {
    logic accept;
    logic packet;
    logic tick;
    logic close;
    logic touching;
  } wd_req_t;

  // Watchdog status toward the merge stage
  typedef struct packed {
    logic release_now;
    logic armed;
    logic held;
  } wd_stat_t;

  // Mirror a coordinate against a size, wrapping mod 2^16
  function automatic logic [15:0] flip16(input logic [15:0] size, input logic [15:0] v);
    flip16 = size - 16'd1 - v;
  endfunction

endpackage

>>> design/touch_point_transform_watchdog.sv
// Top level of the touch point transform watchdog.
// Usage:
//   in_*  : one beat per packet, tick or close item (valid/stall handshake).
//           A packet carries two touch points, each transformed in its own lane.
//   out_* : zero or one frame per item: a packet report frame for every packet,
//           a release-all frame for a close or for a tick that expires the
//           watchdog. Ticks that do not expire and unknown codes give nothing.
//   cfg_* : register writes (valid/ready, ready always high); the user must write
//           them only while idle, which the block itself does not enforce.
// Throughput: one item per cycle while in_stall is low; both lanes and the watchdog
//   finish in the accept cycle and the merged frame lands in the output register or skid.
// Stall: an output register plus a one-entry skid keeps accepting while a frame
//   waits; in_stall rises only when the skid entry is occupied.
// Reset: synchronous, active low; clears the watchdog, the output and skid
//   valid flags, and loads the register defaults.
module touch_point_transform_watchdog #(
  parameter int COUNT_BITS = tptw_pkg::COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tptw_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tptw_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tptw_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]                        cfg_data
);

  tptw_pkg::cfg_t       cfg;
  tptw_pkg::point_in_t  pt_a, pt_b;
  tptw_pkg::point_out_t res_a, res_b;
  tptw_pkg::wd_req_t    wd_req;
  tptw_pkg::wd_stat_t   wd_stat;
  tptw_pkg::out_item_t  frame;
  tptw_pkg::out_item_t  out_r, out_nxt;
  tptw_pkg::out_item_t  skid_r, skid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic                 accept;
  logic                 frame_valid;
  logic                 out_fire;

  assign cfg_ready = 1'b1;

  tptw_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Split the beat into the two point lanes
  always_comb begin
    pt_a.slot  = in_data.first_slot;
    pt_a.state = in_data.first_state;
    pt_a.x     = in_data.first_x;
    pt_a.y     = in_data.first_y;
    pt_b.slot  = in_data.second_slot;
    pt_b.state = in_data.second_state;
    pt_b.x     = in_data.second_x;
    pt_b.y     = in_data.second_y;
  end

  tptw_lane u_lane_a (.cfg(cfg), .pt(pt_a), .res(res_a));
  tptw_lane u_lane_b (.cfg(cfg), .pt(pt_b), .res(res_b));

  assign accept = in_valid && !in_stall;

  always_comb begin
    wd_req.accept   = accept;
    wd_req.packet   = (in_data.func == tptw_pkg::FUNC_PACKET);
    wd_req.tick     = (in_data.func == tptw_pkg::FUNC_TICK);
    wd_req.close    = (in_data.func == tptw_pkg::FUNC_CLOSE);
    wd_req.touching = res_a.active | res_b.active;
  end

  tptw_watchdog #(.COUNT_BITS(COUNT_BITS)) u_watchdog (
    .clk            (clk),
    .rst_n          (rst_n),
    .watchdog_ticks (cfg.watchdog_ticks),
    .req            (wd_req),
    .stat           (wd_stat)
  );

  // Merge lane results or build a release-all frame
  always_comb begin
    frame = '0;
    if (wd_req.packet) begin
      frame.frame_kind      = 1'b0;
      frame.first_used      = res_a.used;
      frame.first_slot_out  = res_a.slot;
      frame.first_active    = res_a.active;
      frame.first_disp_x    = res_a.disp_x;
      frame.first_disp_y    = res_a.disp_y;
      frame.second_used     = res_b.used;
      frame.second_slot_out = res_b.slot;
      frame.second_active   = res_b.active;
      frame.second_disp_x   = res_b.disp_x;
      frame.second_disp_y   = res_b.disp_y;
    end else begin
      frame.frame_kind      = 1'b1;
      frame.first_used      = 1'b1;
      frame.first_slot_out  = 1'b0;
      frame.second_used     = 1'b1;
      frame.second_slot_out = 1'b1;
    end
  end

  assign frame_valid = accept && (wd_req.packet || wd_stat.release_now);
  assign out_fire    = out_valid_r && !out_stall;

  // Output register with skid: drain skid first, park a frame when stalled
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = frame;
        out_valid_nxt = frame_valid;
      end
    end else if (frame_valid) begin
      skid_nxt       = frame;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Skid entry is only used behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output entry");

  // Armed watchdog implies a held touch
  a_armed_held: assert property (@(posedge clk) disable iff (!rst_n)
    wd_stat.armed |-> wd_stat.held)
    else $error("watchdog armed without held touch");

  // Release frames never report an active finger
  a_release_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_kind) |-> (!out_r.first_active && !out_r.second_active))
    else $error("release frame carries an active point");

  // An accepted close always yields a frame on the output
  a_close_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && wd_req.close) |=> out_valid_r)
    else $error("close beat produced no frame");
`endif

endmodule

>>> design/tptw_regs.sv
// Configuration register file for the touch point transform watchdog.
module tptw_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [tptw_pkg::CFG_IDX_BITS-1:0] wr_index,
  input  logic [15:0]                        wr_data,
  output tptw_pkg::cfg_t                     cfg
);

  tptw_pkg::cfg_t cfg_r;
  tptw_pkg::cfg_t cfg_nxt;

  // Decode the write index
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        tptw_pkg::REG_PANEL_WIDTH:    cfg_nxt.panel_width    = wr_data;
        tptw_pkg::REG_PANEL_HEIGHT:   cfg_nxt.panel_height   = wr_data;
        tptw_pkg::REG_SWAP_AXES:      cfg_nxt.swap_axes      = wr_data[0];
        tptw_pkg::REG_MIRROR_RAW_X:   cfg_nxt.mirror_raw_x   = wr_data[0];
        tptw_pkg::REG_MIRROR_RAW_Y:   cfg_nxt.mirror_raw_y   = wr_data[0];
        tptw_pkg::REG_QUARTER_TURNS:  cfg_nxt.quarter_turns  = wr_data[1:0];
        tptw_pkg::REG_REFLECT_MODE:   cfg_nxt.reflect_mode   = wr_data[1:0];
        tptw_pkg::REG_WATCHDOG_TICKS: cfg_nxt.watchdog_ticks = wr_data;
        default: ;
      endcase
    end
  end

  // Hold the registers, load defaults at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width    <= 16'd480;
      cfg_r.panel_height   <= 16'd320;
      cfg_r.swap_axes      <= 1'b0;
      cfg_r.mirror_raw_x   <= 1'b0;
      cfg_r.mirror_raw_y   <= 1'b0;
      cfg_r.quarter_turns  <= tptw_pkg::ROT_NONE;
      cfg_r.reflect_mode   <= 2'd0;
      cfg_r.watchdog_ticks <= 16'd200;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/tptw_lane.sv
// One point lane: slot check, swap, mirror, reflect and rotate.
module tptw_lane (
  input  tptw_pkg::cfg_t       cfg,
  input  tptw_pkg::point_in_t  pt,
  output tptw_pkg::point_out_t res
);

  logic        used;
  logic        act;
  logic [15:0] sx, sy;
  logic [15:0] mx, my;
  logic [15:0] nx, ny;
  logic [15:0] rx, ry;

  // Swap then mirror the raw coordinates
  always_comb begin
    used = (pt.slot < 8'(tptw_pkg::NUM_SLOTS));
    act  = (pt.state == tptw_pkg::ACTIVE_STATE);
    sx   = cfg.swap_axes ? pt.y : pt.x;
    sy   = cfg.swap_axes ? pt.x : pt.y;
    mx   = cfg.mirror_raw_x ? tptw_pkg::flip16(cfg.panel_width, sx) : sx;
    my   = cfg.mirror_raw_y ? tptw_pkg::flip16(cfg.panel_height, sy) : sy;
  end

  // Reflect, then rotate into display coordinates
  always_comb begin
    nx = cfg.reflect_mode[0] ? tptw_pkg::flip16(cfg.panel_width, mx) : mx;
    ny = cfg.reflect_mode[1] ? tptw_pkg::flip16(cfg.panel_height, my) : my;
    case (cfg.quarter_turns)
      tptw_pkg::ROT_90: begin
        rx = ny;
        ry = tptw_pkg::flip16(cfg.panel_width, nx);
      end
      tptw_pkg::ROT_180: begin
        rx = tptw_pkg::flip16(cfg.panel_width, nx);
        ry = tptw_pkg::flip16(cfg.panel_height, ny);
      end
      tptw_pkg::ROT_270: begin
        rx = tptw_pkg::flip16(cfg.panel_height, ny);
        ry = nx;
      end
      default: begin
        rx = nx;
        ry = ny;
      end
    endcase
  end

  // Zero every field that does not apply
  always_comb begin
    res.used   = used;
    res.slot   = used & pt.slot[0];
    res.active = used & act;
    res.disp_x = (used && act) ? rx : 16'd0;
    res.disp_y = (used && act) ? ry : 16'd0;
  end

endmodule

>>> design/tptw_watchdog.sv
// Release watchdog: touch held flag, arm flag and tick countdown.
module tptw_watchdog #(
  parameter int COUNT_BITS = tptw_pkg::COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        watchdog_ticks,
  input  tptw_pkg::wd_req_t  req,
  output tptw_pkg::wd_stat_t stat
);

  logic                  held_r, held_nxt;
  logic                  armed_r, armed_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] load_val;
  logic                  expire;

  // Saturate the reload value to the counter width
  if (COUNT_BITS >= 16) begin : g_wide
    assign load_val = COUNT_BITS'(watchdog_ticks);
  end else begin : g_narrow
    assign load_val = (|watchdog_ticks[15:COUNT_BITS]) ? '1
                                                       : watchdog_ticks[COUNT_BITS-1:0];
  end

  assign expire = armed_r && (count_r <= COUNT_BITS'(1));

  // Advance the watchdog on each accepted beat
  always_comb begin
    held_nxt  = held_r;
    armed_nxt = armed_r;
    count_nxt = count_r;
    if (req.accept) begin
      if (req.packet) begin
        if (req.touching) begin
          held_nxt  = 1'b1;
          armed_nxt = 1'b1;
          count_nxt = load_val;
        end else if (held_r) begin
          held_nxt  = 1'b0;
          armed_nxt = 1'b0;
        end
      end else if (req.tick && armed_r) begin
        if (expire) begin
          held_nxt  = 1'b0;
          armed_nxt = 1'b0;
          count_nxt = '0;
        end else begin
          count_nxt = count_r - COUNT_BITS'(1);
        end
      end else if (req.close) begin
        held_nxt  = 1'b0;
        armed_nxt = 1'b0;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      armed_r <= 1'b0;
      count_r <= '0;
    end else begin
      held_r  <= held_nxt;
      armed_r <= armed_nxt;
      count_r <= count_nxt;
    end
  end

  // Report a release frame for an expiring tick or a close
  assign stat.release_now = (req.tick && expire) || req.close;
  assign stat.armed       = armed_r;
  assign stat.held        = held_r;

endmodule
